[hdl/assert_macros.svh]
// Assertion helpers; clocked on i_clk of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALL(lbl, prop, msg)
`endif
`endif

[hdl/wrrm_pkg.sv]
package wrrm_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 16;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DGR_SHIFT    = 13;
    localparam int DGR_W        = SAMPLE_W + DGR_SHIFT;
    localparam int DIV_W        = (SUM_W > DGR_W) ? SUM_W : DGR_W;
    localparam int CNT_W        = $clog2(DIV_W);

    localparam logic [SAMPLE_W-1:0] HALF_Q412     = 16'd2048;
    localparam logic [SAMPLE_W-1:0] LOW_RESET     = 16'd1024;
    localparam logic [SAMPLE_W-1:0] HIGH_RESET    = 16'd3072;
    localparam logic [SAMPLE_W-1:0] FRAC_RESET    = 16'd6554;
    localparam logic [SAMPLE_W-1:0] REPORT_RESET  = 16'd2048;
    localparam logic [SAMPLE_W-1:0] DANGER_SAT    = 16'hFFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC = 2'd2;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [SAMPLE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hdl/windowed_ratio_range_monitor.sv]
// Moving-average range monitor for eye-ratio samples (unsigned Q4.12). Each
// input item gives exactly one result item. Both the window average and the
// relative danger come out of one shared bit-serial divider that resolves one
// quotient bit per cycle over DIV_W (29) bits. An item with a valid sample and
// high_bound above low_bound runs the divider twice; any other item runs it
// once. A stalled result holds the next item in S_OUT until the output register
// frees. The next item can be accepted at the same edge as the result is taken,
// and is taken while the previous result still waits in the output register.
// Registers: 0 low_bound, 1 high_bound, 2 change_fraction; other indexes are
// ignored. Write them only while the block is idle.
`include "assert_macros.svh"

module windowed_ratio_range_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] ratio_sample
    input  logic [2:0]  i_s_tuser,   // [0] sample_valid, [1] tuning_active, [2] clear_danger
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] window_average, [31:16] relative_danger,
                                     // [47:32] reported_value
    output logic [2:0]  o_m_tuser,   // [0] in_danger, [1] alarm_raised, [2] value_reported
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [wrrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_AVG_GO, S_AVG_RUN, S_DGR_GO, S_DGR_RUN, S_CHECK, S_OUT
    } t_state;

    t_state                          r_state;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_low;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_high;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_frac;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_win [wrrm_pkg::WINDOW_DEPTH];
    logic [wrrm_pkg::SLOT_W-1:0]     r_slot;
    logic [wrrm_pkg::SUM_W-1:0]      r_sum;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_last;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_held;
    logic                            r_latched;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_sample;
    logic                            r_valid;
    logic                            r_tuning;
    logic [wrrm_pkg::SAMPLE_W-1:0]   r_avg;
    logic [2*wrrm_pkg::SAMPLE_W-1:0] r_prod;
    logic                            r_alarm;
    logic                            r_reported;
    logic                            r_m_tvalid;
    logic [47:0]                     r_m_tdata;
    logic [2:0]                      r_m_tuser;

    logic [wrrm_pkg::SUM_W-1:0]      n_sum;
    logic [wrrm_pkg::SAMPLE_W-1:0]   n_mid;
    logic [wrrm_pkg::SAMPLE_W-1:0]   n_dev;
    logic [wrrm_pkg::SAMPLE_W-1:0]   n_range;
    logic                            n_band_ok;
    logic [wrrm_pkg::SAMPLE_W-1:0]   n_rep_diff;
    logic                            n_outside;
    logic                            n_out_free;
    wrrm_pkg::t_div_req              n_req;
    wrrm_pkg::t_div_rsp              w_rsp;

    always_comb begin
        n_sum      = r_sum - wrrm_pkg::SUM_W'(r_win[r_slot]) + wrrm_pkg::SUM_W'(r_sample);
        n_mid      = wrrm_pkg::SAMPLE_W'(({1'b0, r_low} + {1'b0, r_high}) >> 1);
        n_dev      = (r_avg >= n_mid) ? (r_avg - n_mid) : (n_mid - r_avg);
        n_range    = r_high - r_low;
        n_band_ok  = r_high > r_low;
        n_rep_diff = (r_avg >= r_last) ? (r_avg - r_last) : (r_last - r_avg);
        n_outside  = (r_avg < r_low) || (r_avg > r_high);
        n_out_free = !r_m_tvalid || i_m_tready;

        n_req.start    = 1'b0;
        n_req.dividend = wrrm_pkg::DIV_W'(r_sum);
        n_req.divisor  = wrrm_pkg::SAMPLE_W'(wrrm_pkg::WINDOW_DEPTH);
        case (r_state)
            S_AVG_GO: begin
                n_req.start = 1'b1;
            end
            S_DGR_GO: begin
                n_req.start    = r_valid && n_band_ok;
                n_req.dividend = wrrm_pkg::DIV_W'({n_dev, {wrrm_pkg::DGR_SHIFT{1'b0}}});
                n_req.divisor  = n_range;
            end
            default: begin
                n_req.start = 1'b0;
            end
        endcase
    end

    wrrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_low      <= wrrm_pkg::LOW_RESET;
            r_high     <= wrrm_pkg::HIGH_RESET;
            r_frac     <= wrrm_pkg::FRAC_RESET;
            for (int i = 0; i < wrrm_pkg::WINDOW_DEPTH; i++) begin
                r_win[i] <= wrrm_pkg::HALF_Q412;
            end
            r_slot     <= '0;
            r_sum      <= wrrm_pkg::SUM_W'(int'(wrrm_pkg::HALF_Q412) * wrrm_pkg::WINDOW_DEPTH);
            r_last     <= wrrm_pkg::REPORT_RESET;
            r_held     <= '0;
            r_latched  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wrrm_pkg::CFG_LOW:  r_low  <= i_cfg_data;
                    wrrm_pkg::CFG_HIGH: r_high <= i_cfg_data;
                    wrrm_pkg::CFG_FRAC: r_frac <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_m_tvalid && i_m_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_sample   <= i_s_tdata;
                        r_valid    <= i_s_tuser[0];
                        r_tuning   <= i_s_tuser[1];
                        r_alarm    <= 1'b0;
                        r_reported <= 1'b0;
                        if (i_s_tuser[2]) begin
                            r_latched <= 1'b0;
                        end
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_valid) begin
                        r_sum         <= n_sum;
                        r_win[r_slot] <= r_sample;
                        r_slot <= (r_slot == wrrm_pkg::SLOT_W'(wrrm_pkg::WINDOW_DEPTH - 1))
                                  ? '0 : r_slot + 1'b1;
                    end
                    r_state <= S_AVG_GO;
                end
                S_AVG_GO: begin
                    r_state <= S_AVG_RUN;
                end
                S_AVG_RUN: begin
                    if (w_rsp.done) begin
                        r_avg   <= w_rsp.quotient[wrrm_pkg::SAMPLE_W-1:0];
                        r_state <= S_DGR_GO;
                    end
                end
                S_DGR_GO: begin
                    r_prod <= {{wrrm_pkg::SAMPLE_W{1'b0}}, r_frac}
                              * {{wrrm_pkg::SAMPLE_W{1'b0}}, n_range};
                    if (r_valid && n_band_ok) begin
                        r_state <= S_DGR_RUN;
                    end else begin
                        if (r_valid) begin
                            r_held <= (n_dev == '0) ? '0 : wrrm_pkg::DANGER_SAT;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_DGR_RUN: begin
                    if (w_rsp.done) begin
                        r_held  <= (w_rsp.quotient[wrrm_pkg::DIV_W-1:wrrm_pkg::SAMPLE_W] != '0)
                                   ? wrrm_pkg::DANGER_SAT
                                   : w_rsp.quotient[wrrm_pkg::SAMPLE_W-1:0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_tuning) begin
                        if (n_outside) begin
                            r_alarm   <= !r_latched;
                            r_latched <= 1'b1;
                        end else if (r_valid
                                     && ({n_rep_diff, {wrrm_pkg::SAMPLE_W{1'b0}}} >= r_prod))
                        begin
                            r_last     <= r_avg;
                            r_reported <= 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {r_last, r_held, r_avg};
                        r_m_tuser  <= {r_reported, r_alarm, r_latched};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;

    `ASSERT_RST(a_alarm_latches, o_m_tvalid |-> (!o_m_tuser[1] || o_m_tuser[0]), "alarm unlatched")
    `ASSERT_RST(a_alarm_xor_report, o_m_tvalid |-> !(o_m_tuser[1] && o_m_tuser[2]), "alarm+report")
    `ASSERT_RST(a_slot_range, r_slot <= wrrm_pkg::SLOT_W'(wrrm_pkg::WINDOW_DEPTH - 1), "bad slot")

endmodule

[hdl/wrrm_div.sv]
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module wrrm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrrm_pkg::t_div_req i_req,
    output wrrm_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [wrrm_pkg::CNT_W-1:0]    r_cnt;
    logic [wrrm_pkg::DIV_W-1:0]    r_num;
    logic [wrrm_pkg::SAMPLE_W-1:0] r_rem;
    logic [wrrm_pkg::SAMPLE_W-1:0] r_den;

    logic [wrrm_pkg::SAMPLE_W:0]   n_trial;
    logic                          n_ge;
    logic [wrrm_pkg::SAMPLE_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_num[wrrm_pkg::DIV_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= wrrm_pkg::CNT_W'(wrrm_pkg::DIV_W - 1);
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[wrrm_pkg::DIV_W-2:0], n_ge};
                r_rem <= n_ge ? n_diff[wrrm_pkg::SAMPLE_W-1:0]
                              : n_trial[wrrm_pkg::SAMPLE_W-1:0];
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

    `ASSERT_RST(a_start_idle, i_req.start |-> !r_busy, "divider restarted while busy")
    `ASSERT_RST(a_done_after_busy, r_done |-> $past(r_busy), "done without a run")
    `ASSERT_RST(a_done_pulse, r_done |=> !r_done, "done held longer than one cycle")

endmodule

[sim/wrrm_checker.sv]
module wrrm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] ratio_sample
    input  logic [2:0]  i_s_tuser,   // [0] sample_valid, [1] tuning_active, [2] clear_danger
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // [15:0] window_average, [31:16] relative_danger,
                                     // [47:32] reported_value
    input  logic [2:0]  i_m_tuser,   // [0] in_danger, [1] alarm_raised, [2] value_reported
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [wrrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_alarms,
    output int          o_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic clear_danger;
        logic tuning_active;
        logic sample_valid;
    } t_sample_flags;

    typedef struct {
        logic [15:0] window_average;
        logic [15:0] relative_danger;
        logic        in_danger;
        logic        alarm_raised;
        logic        value_reported;
        logic [15:0] reported_value;
    } t_monitor_result;

    // mirror of the block's registers and state
    logic [15:0]                low_bound;
    logic [15:0]                high_bound;
    logic [15:0]                change_frac;
    logic [15:0]                ratio_window [wrrm_pkg::WINDOW_DEPTH];
    int unsigned                oldest_slot;
    logic [wrrm_pkg::SUM_W-1:0] ratio_sum;
    logic [15:0]                last_reported;
    logic [15:0]                held_danger;
    logic                       danger_latched;

    t_monitor_result expected_results [$];

    function automatic logic [15:0] abs_delta(logic [15:0] a, logic [15:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // |avg - mid| * 2 / range in Q4.12, saturated
    function automatic logic [15:0] danger_of(logic [15:0] avg);
        logic [16:0] mid_sum;
        logic [15:0] dev;
        logic [63:0] quot;
        mid_sum = {1'b0, low_bound} + {1'b0, high_bound};
        dev = abs_delta(avg, mid_sum[16:1]);
        if (high_bound <= low_bound) begin
            return (dev == 16'd0) ? 16'd0 : wrrm_pkg::DANGER_SAT;
        end
        quot = (64'(dev) << 13) / (64'(high_bound) - 64'(low_bound));
        return (quot > 64'(wrrm_pkg::DANGER_SAT)) ? wrrm_pkg::DANGER_SAT : quot[15:0];
    endfunction

    task automatic predict_result(input logic [15:0] sample, input t_sample_flags flags,
                                  output t_monitor_result res);
        logic [15:0] avg;
        logic [63:0] moved;
        logic [63:0] needed;
        res.alarm_raised   = 1'b0;
        res.value_reported = 1'b0;
        if (flags.clear_danger) begin
            danger_latched = 1'b0;
        end
        if (flags.sample_valid) begin
            ratio_sum = ratio_sum - ratio_window[oldest_slot] + sample;
            ratio_window[oldest_slot] = sample;
            oldest_slot = (oldest_slot + 1) % wrrm_pkg::WINDOW_DEPTH;
        end
        avg = 16'(ratio_sum / wrrm_pkg::WINDOW_DEPTH);
        if (flags.sample_valid) begin
            held_danger = danger_of(avg);
        end
        if (!flags.tuning_active) begin
            if (avg < low_bound || avg > high_bound) begin
                res.alarm_raised = !danger_latched;
                danger_latched = 1'b1;
            end else if (flags.sample_valid) begin
                moved  = 64'(abs_delta(avg, last_reported)) << 16;
                needed = 64'(change_frac) * (64'(high_bound) - 64'(low_bound));
                if (moved >= needed) begin
                    last_reported = avg;
                    res.value_reported = 1'b1;
                end
            end
        end
        res.window_average  = avg;
        res.relative_danger = held_danger;
        res.in_danger       = danger_latched;
        res.reported_value  = last_reported;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_monitor_result want;
        t_monitor_result got;
        if (!i_rst_n) begin
            low_bound      = wrrm_pkg::LOW_RESET;
            high_bound     = wrrm_pkg::HIGH_RESET;
            change_frac    = wrrm_pkg::FRAC_RESET;
            for (int i = 0; i < wrrm_pkg::WINDOW_DEPTH; i++) begin
                ratio_window[i] = wrrm_pkg::HALF_Q412;
            end
            oldest_slot    = 0;
            ratio_sum      = wrrm_pkg::SUM_W'(int'(wrrm_pkg::HALF_Q412) * wrrm_pkg::WINDOW_DEPTH);
            last_reported  = wrrm_pkg::REPORT_RESET;
            held_danger    = 16'd0;
            danger_latched = 1'b0;
            expected_results.delete();
            o_fail_count   = 0;
            o_checked      = 0;
            o_alarms       = 0;
            o_reports      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wrrm_pkg::CFG_LOW:  low_bound   = i_cfg_data;
                    wrrm_pkg::CFG_HIGH: high_bound  = i_cfg_data;
                    wrrm_pkg::CFG_FRAC: change_frac = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_result(i_s_tdata, t_sample_flags'(i_s_tuser), want);
                expected_results.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation pending: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    got.window_average  = i_m_tdata[15:0];
                    got.relative_danger = i_m_tdata[31:16];
                    got.reported_value  = i_m_tdata[47:32];
                    got.in_danger       = i_m_tuser[0];
                    got.alarm_raised    = i_m_tuser[1];
                    got.value_reported  = i_m_tuser[2];
                    check_field("window_average", want.window_average, got.window_average);
                    check_field("relative_danger", want.relative_danger,
                                got.relative_danger);
                    check_field("in_danger", 16'(want.in_danger), 16'(got.in_danger));
                    check_field("alarm_raised", 16'(want.alarm_raised), 16'(got.alarm_raised));
                    check_field("value_reported", 16'(want.value_reported),
                                16'(got.value_reported));
                    check_field("reported_value", want.reported_value, got.reported_value);
                    o_checked++;
                    if (want.alarm_raised) o_alarms++;
                    if (want.value_reported) o_reports++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [wrrm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [wrrm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int alarms;
    int reports;

    int idle_pct;
    int stall_pct;
    int items_sent;
    int settings_used;
    int band_lo;
    int band_hi;
    int target;

    windowed_ratio_range_monitor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wrrm_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_alarms     (alarms),
        .o_reports    (reports)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(negedge clk) begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still pending", pending);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_sample(input logic [15:0] sample, input logic valid,
                               input logic tuning, input logic clear);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sample;
        s_tuser  = {clear, tuning, valid};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // sender holds off until every result is back and the divider is quiet
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [wrrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            wrrm_pkg::CFG_LOW:  band_lo = value;
            wrrm_pkg::CFG_HIGH: band_hi = value;
            default: ;
        endcase
    endtask

    task automatic set_band(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] frac);
        drain_results();
        write_reg(wrrm_pkg::CFG_LOW, lo);
        write_reg(wrrm_pkg::CFG_HIGH, hi);
        write_reg(wrrm_pkg::CFG_FRAC, frac);
        settings_used++;
    endtask

    // drifting target so the average walks into and out of the band
    function automatic logic [15:0] next_sample();
        int val;
        if ($urandom_range(11) == 0) begin
            case ($urandom_range(3))
                0: target = $urandom_range(band_lo, 0);
                1: target = $urandom_range(65535, band_hi);
                2: target = (band_hi >= band_lo) ? $urandom_range(band_hi, band_lo)
                                                 : $urandom_range(65535);
                default: target = $urandom_range(65535);
            endcase
        end
        case ($urandom_range(9))
            0: return 16'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: begin
                val = target + int'($urandom_range(512)) - 256;
                if (val < 0) val = 0;
                if (val > 65535) val = 65535;
                return 16'(val);
            end
        endcase
    endfunction

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = wrrm_pkg::CFG_LOW;
        cfg_data      = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        settings_used = 1;
        band_lo       = wrrm_pkg::LOW_RESET;
        band_hi       = wrrm_pkg::HIGH_RESET;
        target        = wrrm_pkg::HALF_Q412;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset bounds: extremes, clear while out of band, invalid and tuning items
        send_sample(16'h0000, 1'b1, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0, 1'b1);
        send_sample(16'h1234, 1'b0, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0, 1'b1);
        send_sample(16'h0000, 1'b1, 1'b1, 1'b0);
        send_sample(16'h0800, 1'b1, 1'b1, 1'b1);
        send_sample(16'h0800, 1'b0, 1'b1, 1'b0);

        // widest band, zero threshold: every valid in-band item reports
        set_band(16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 1'b1, 1'b0, 1'b1);
        send_sample(16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_sample(16'h0800, 1'b0, 1'b0, 1'b0);

        // full threshold
        set_band(16'h0000, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b0, 1'b0);

        // equal bounds
        set_band(16'h0C00, 16'h0C00, 16'h1999);
        send_sample(16'h0C00, 1'b1, 1'b0, 1'b1);
        send_sample(16'h0000, 1'b1, 1'b0, 1'b0);
        send_sample(16'h0C00, 1'b0, 1'b0, 1'b1);

        // inverted bounds: always out of band
        set_band(16'h0C00, 16'h0400, 16'h1999);
        send_sample(16'h0800, 1'b1, 1'b0, 1'b1);
        send_sample(16'h0800, 1'b0, 1'b0, 1'b1);

        // write to an unused index must change nothing
        drain_results();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_sample(16'h0800, 1'b1, 1'b0, 1'b1);
        send_sample(16'h0800, 1'b1, 1'b1, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_band(wrrm_pkg::LOW_RESET, wrrm_pkg::HIGH_RESET, wrrm_pkg::FRAC_RESET);
                1: set_band(16'h0000, 16'hFFFF, 16'h0000);
                2: begin
                    band_lo = $urandom_range(4000);
                    set_band(16'(band_lo), 16'(band_lo + $urandom_range(4000, 1)),
                             16'($urandom_range(65535)));
                end
                3: set_band(16'h0800, 16'h0800, 16'($urandom_range(65535)));
                4: set_band(16'd3000, 16'd1000, 16'($urandom_range(65535)));
                5: set_band(16'd1500, 16'd2600, 16'hFFFF);
                6: set_band(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            16'($urandom_range(65535)));
                default: begin
                    band_lo = $urandom_range(3000, 200);
                    set_band(16'(band_lo), 16'(band_lo + $urandom_range(3000, 100)),
                             16'($urandom_range(2000)));
                end
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_sample(next_sample(), $urandom_range(99) < 85,
                            $urandom_range(9) == 0, $urandom_range(7) == 0);
            end
        end

        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (100) @(posedge clk);

        $display("Sent %0d items over %0d band settings, all idle and stall mixes",
                 items_sent, settings_used);
        $display("Checked %0d results: %0d alarms, %0d report updates, %0d pending",
                 checked, alarms, reports, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
